// File: rtl/psvf_pkg.sv
package psvf_pkg;

    // Field and register widths.
    localparam int VP_W      = 16;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;

    // Datapath widths. Sizes are held up to the internal cap of 2^34.
    localparam int SIZE_W = 35;
    localparam int PROD_W = 51;
    localparam int PA_W   = 50;
    localparam int ACC_W  = 66;
    localparam int REM_W  = 31;
    localparam int CNT_W  = 7;

    localparam logic [SIZE_W-1:0] SIZE_CAP = 35'h4_0000_0000;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VIEW_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_MARGIN   = 2'd3;

    localparam logic [VP_W-1:0]  VIEWPORT_WIDTH_RST  = 16'd1920;
    localparam logic [VP_W-1:0]  VIEWPORT_HEIGHT_RST = 16'd1080;
    localparam logic [CFG_W-1:0] MIN_VIEW_HEIGHT_RST = 31'd655360;
    localparam logic [CFG_W-1:0] BORDER_MARGIN_RST   = 31'd65536;

    // Multiplier step codes.
    localparam logic [1:0] MSTEP_NONE = 2'd0;
    localparam logic [1:0] MSTEP_LO   = 2'd1;
    localparam logic [1:0] MSTEP_HI   = 2'd2;
    localparam logic [1:0] MSTEP_ADD  = 2'd3;

    // Multiplier operand pairs.
    localparam logic [1:0] MOP_SY_W   = 2'd0;
    localparam logic [1:0] MOP_SX_H   = 2'd1;
    localparam logic [1:0] MOP_MIN_W  = 2'd2;
    localparam logic [1:0] MOP_SX_MIN = 2'd3;

    // Divider operations: divisor and destination.
    localparam logic [1:0] DOP_H_SX  = 2'd0;
    localparam logic [1:0] DOP_W_SY  = 2'd1;
    localparam logic [1:0] DOP_SY_SX = 2'd2;

    typedef struct packed {
        logic [VP_W-1:0]  viewport_width;
        logic [VP_W-1:0]  viewport_height;
        logic [CFG_W-1:0] min_view_height;
        logic [CFG_W-1:0] border_margin;
    } cfg_t;

    typedef struct packed {
        logic       pt_take;
        logic       pt_first;
        logic       box_load;
        logic [1:0] mul_step;
        logic [1:0] mul_op;
        logic       save_pa;
        logic       cmp_pick;
        logic       div_start;
        logic       div_step;
        logic [1:0] div_op;
        logic       div_write;
        logic       sy_to_min;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic wide;
        logic sy_zero;
        logic sy_below_min;
    } sts_t;

endpackage

// File: rtl/psvf_cfg.sv
module psvf_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [psvf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psvf_pkg::CFG_W-1:0]       cfg_wdata,
    output psvf_pkg::cfg_t                   cfg
);

    psvf_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.viewport_width  <= psvf_pkg::VIEWPORT_WIDTH_RST;
            cfg_reg.viewport_height <= psvf_pkg::VIEWPORT_HEIGHT_RST;
            cfg_reg.min_view_height <= psvf_pkg::MIN_VIEW_HEIGHT_RST;
            cfg_reg.border_margin   <= psvf_pkg::BORDER_MARGIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                psvf_pkg::REG_VIEWPORT_WIDTH:
                    cfg_reg.viewport_width <= cfg_wdata[psvf_pkg::VP_W-1:0];
                psvf_pkg::REG_VIEWPORT_HEIGHT:
                    cfg_reg.viewport_height <= cfg_wdata[psvf_pkg::VP_W-1:0];
                psvf_pkg::REG_MIN_VIEW_HEIGHT:
                    cfg_reg.min_view_height <= cfg_wdata;
                psvf_pkg::REG_BORDER_MARGIN:
                    cfg_reg.border_margin <= cfg_wdata;
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/psvf_ctrl.sv
module psvf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           is_last,
    input  logic           out_ready,
    input  psvf_pkg::sts_t sts,
    output logic           in_ready,
    output logic           out_valid,
    output psvf_pkg::cmd_t cmd
);

    localparam logic [3:0] ST_ACCUM     = 4'd0;
    localparam logic [3:0] ST_BOX       = 4'd1;
    localparam logic [3:0] ST_MUL_LO    = 4'd2;
    localparam logic [3:0] ST_MUL_HI    = 4'd3;
    localparam logic [3:0] ST_MUL_ADD   = 4'd4;
    localparam logic [3:0] ST_CMP       = 4'd5;
    localparam logic [3:0] ST_DIV_START = 4'd6;
    localparam logic [3:0] ST_DIV_STEP  = 4'd7;
    localparam logic [3:0] ST_DIV_WRITE = 4'd8;
    localparam logic [3:0] ST_ZCHK      = 4'd9;
    localparam logic [3:0] ST_OUT       = 4'd10;

    // Which product or quotient the shared multiply and divide unit works on.
    localparam logic [2:0] PH_ASPECT_A   = 3'd0;
    localparam logic [2:0] PH_ASPECT_B   = 3'd1;
    localparam logic [2:0] PH_ASPECT_DIV = 3'd2;
    localparam logic [2:0] PH_ZOOM       = 3'd3;
    localparam logic [2:0] PH_ZERO       = 3'd4;

    localparam logic [psvf_pkg::CNT_W-1:0] DIV_LAST = psvf_pkg::CNT_W'(psvf_pkg::ACC_W - 1);

    logic [3:0]                   state_reg, state_next;
    logic [2:0]                   phase_reg, phase_next;
    logic [psvf_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                         first_reg, first_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         in_fire;
    logic [1:0]                   mul_op;
    logic [1:0]                   div_op;

    assign in_ready = (state_reg == ST_ACCUM);
    assign in_fire  = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        case (phase_reg)
            PH_ASPECT_A: mul_op = psvf_pkg::MOP_SY_W;
            PH_ASPECT_B: mul_op = psvf_pkg::MOP_SX_H;
            PH_ZOOM:     mul_op = psvf_pkg::MOP_SX_MIN;
            default:     mul_op = psvf_pkg::MOP_MIN_W;
        endcase
        case (phase_reg)
            PH_ZOOM:       div_op = psvf_pkg::DOP_SY_SX;
            PH_ZERO:       div_op = psvf_pkg::DOP_H_SX;
            default:       div_op = sts.wide ? psvf_pkg::DOP_H_SX : psvf_pkg::DOP_W_SY;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.mul_op = mul_op;
        cmd.div_op = div_op;
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        first_next = first_reg;

        unique case (state_reg)
            ST_ACCUM:
            begin
                cmd.pt_take  = in_fire;
                cmd.pt_first = first_reg;
                if (in_fire)
                begin
                    first_next = is_last;
                    if (is_last)
                    begin
                        state_next = ST_BOX;
                    end
                end
            end
            ST_BOX:
            begin
                cmd.box_load = 1'b1;
                phase_next   = PH_ASPECT_A;
                state_next   = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                cmd.mul_step = psvf_pkg::MSTEP_LO;
                cmd.save_pa  = (phase_reg == PH_ASPECT_B);
                state_next   = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.mul_step = psvf_pkg::MSTEP_HI;
                state_next   = ST_MUL_ADD;
            end
            ST_MUL_ADD:
            begin
                cmd.mul_step = psvf_pkg::MSTEP_ADD;
                if (phase_reg == PH_ASPECT_A)
                begin
                    phase_next = PH_ASPECT_B;
                    state_next = ST_MUL_LO;
                end
                else if (phase_reg == PH_ASPECT_B)
                begin
                    state_next = ST_CMP;
                end
                else
                begin
                    state_next = ST_DIV_START;
                end
            end
            ST_CMP:
            begin
                cmd.cmp_pick = 1'b1;
                phase_next   = PH_ASPECT_DIV;
                state_next   = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                cnt_next      = '0;
                state_next    = ST_DIV_STEP;
            end
            ST_DIV_STEP:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_DIV_WRITE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DIV_WRITE:
            begin
                cmd.div_write = 1'b1;
                if (phase_reg == PH_ASPECT_DIV)
                begin
                    state_next = ST_ZCHK;
                end
                else
                begin
                    cmd.sy_to_min = 1'b1;
                    state_next    = ST_OUT;
                end
            end
            ST_ZCHK:
            begin
                if (sts.sy_zero)
                begin
                    phase_next = PH_ZERO;
                    state_next = ST_MUL_LO;
                end
                else if (sts.sy_below_min)
                begin
                    phase_next = PH_ZOOM;
                    state_next = ST_MUL_LO;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    assign out_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            phase_reg     <= PH_ASPECT_A;
            cnt_reg       <= '0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/psvf_dp.sv
module psvf_dp #(
    parameter int COORD_BITS = 32
) (
    input  logic                                clk,
    input  psvf_pkg::cmd_t                      cmd,
    input  psvf_pkg::cfg_t                      cfg,
    input  logic signed [31:0]                  point_x,
    input  logic signed [31:0]                  point_y,
    output psvf_pkg::sts_t                      sts,
    output logic signed [31:0]                  view_x,
    output logic signed [31:0]                  view_y,
    output logic [30:0]                         view_width,
    output logic [30:0]                         view_height
);

    localparam int SIZE_W = psvf_pkg::SIZE_W;
    localparam int ACC_W  = psvf_pkg::ACC_W;
    localparam int PROD_W = psvf_pkg::PROD_W;
    localparam int PA_W   = psvf_pkg::PA_W;
    localparam int REM_W  = psvf_pkg::REM_W;

    localparam int SAT_BITS = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam logic signed [SIZE_W-1:0] CORNER_HI =
        (35'sd1 <<< (SAT_BITS - 1)) - 35'sd1;
    localparam logic signed [SIZE_W-1:0] CORNER_LO = -CORNER_HI - 35'sd1;
    localparam logic [SIZE_W-1:0] SIZE_HI = (35'd1 << (SAT_BITS - 1)) - 35'd1;

    logic signed [31:0]   low_x_reg, high_x_reg, low_y_reg, high_y_reg;
    logic [SIZE_W-1:0]    sx_reg, sy_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [PA_W-1:0]      pa_reg;
    logic                 wide_reg;
    logic [REM_W-1:0]     div_reg, rem_reg;
    logic [SIZE_W-1:0]    q_reg;
    logic                 ovf_reg;
    logic signed [31:0]   view_x_reg, view_y_reg;
    logic [30:0]          view_width_reg, view_height_reg;

    logic [15:0]          w_eff, h_eff;
    logic [32:0]          diff_x, diff_y;
    logic [SIZE_W-1:0]    box_sx, box_sy, min_ext;
    logic [SIZE_W-1:0]    mul_x;
    logic [30:0]          mul_y;
    logic [15:0]          y_part;
    logic [PROD_W-1:0]    prod_next;
    logic [REM_W-1:0]     divisor;
    logic [REM_W:0]       rem_shift, rem_diff;
    logic                 rem_ge;
    logic [SIZE_W-1:0]    q_capped;
    logic signed [35:0]   sum_x, sum_y;
    logic signed [34:0]   half_x, half_y;

    // A viewport register of zero acts as one.
    assign w_eff = (cfg.viewport_width == '0) ? 16'd1 : cfg.viewport_width;
    assign h_eff = (cfg.viewport_height == '0) ? 16'd1 : cfg.viewport_height;
    assign min_ext = {4'b0, cfg.min_view_height};

    // Padded size is the span plus the margin on both sides.
    assign diff_x = {high_x_reg[31], high_x_reg} - {low_x_reg[31], low_x_reg};
    assign diff_y = {high_y_reg[31], high_y_reg} - {low_y_reg[31], low_y_reg};
    assign box_sx = {2'b0, diff_x} + {3'b0, cfg.border_margin, 1'b0};
    assign box_sy = {2'b0, diff_y} + {3'b0, cfg.border_margin, 1'b0};

    always_comb
    begin
        case (cmd.mul_op)
            psvf_pkg::MOP_SY_W:
            begin
                mul_x = sy_reg;
                mul_y = {15'b0, w_eff};
            end
            psvf_pkg::MOP_SX_H:
            begin
                mul_x = sx_reg;
                mul_y = {15'b0, h_eff};
            end
            psvf_pkg::MOP_MIN_W:
            begin
                mul_x = min_ext;
                mul_y = {15'b0, w_eff};
            end
            default:
            begin
                mul_x = sx_reg;
                mul_y = cfg.min_view_height;
            end
        endcase
        case (cmd.div_op)
            psvf_pkg::DOP_W_SY:  divisor = {15'b0, w_eff};
            psvf_pkg::DOP_SY_SX: divisor = sy_reg[REM_W-1:0];
            default:             divisor = {15'b0, h_eff};
        endcase
    end

    // The multiplier is 35 by 16; a 31-bit operand takes two passes.
    assign y_part    = (cmd.mul_step == psvf_pkg::MSTEP_HI) ? {1'b0, mul_y[30:16]} : mul_y[15:0];
    assign prod_next = {16'b0, mul_x} * {35'b0, y_part};

    // Restoring division, one quotient bit per cycle.
    assign rem_shift = {rem_reg, acc_reg[ACC_W-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign rem_ge    = (rem_shift >= {1'b0, div_reg});
    assign q_capped  = (ovf_reg || (q_reg[SIZE_W-1] && (|q_reg[SIZE_W-2:0]))) ?
                       psvf_pkg::SIZE_CAP : q_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.pt_take)
        begin
            if (cmd.pt_first)
            begin
                low_x_reg  <= point_x;
                high_x_reg <= point_x;
                low_y_reg  <= point_y;
                high_y_reg <= point_y;
            end
            else
            begin
                if (point_x < low_x_reg)  low_x_reg  <= point_x;
                if (point_x > high_x_reg) high_x_reg <= point_x;
                if (point_y < low_y_reg)  low_y_reg  <= point_y;
                if (point_y > high_y_reg) high_y_reg <= point_y;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.box_load)
        begin
            sx_reg <= box_sx;
        end
        else if (cmd.div_write && (cmd.div_op != psvf_pkg::DOP_W_SY))
        begin
            sx_reg <= q_capped;
        end

        if (cmd.box_load)
        begin
            sy_reg <= box_sy;
        end
        else if (cmd.sy_to_min)
        begin
            sy_reg <= min_ext;
        end
        else if (cmd.div_write && (cmd.div_op == psvf_pkg::DOP_W_SY))
        begin
            sy_reg <= q_capped;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_step == psvf_pkg::MSTEP_LO || cmd.mul_step == psvf_pkg::MSTEP_HI)
        begin
            prod_reg <= prod_next;
        end

        if (cmd.save_pa)
        begin
            pa_reg <= acc_reg[PA_W-1:0];
        end

        if (cmd.mul_step == psvf_pkg::MSTEP_HI)
        begin
            acc_reg <= {15'b0, prod_reg};
        end
        else if (cmd.mul_step == psvf_pkg::MSTEP_ADD)
        begin
            acc_reg <= acc_reg + {prod_reg[PROD_W-2:0], 16'b0};
        end
        else if (cmd.cmp_pick)
        begin
            if (pa_reg > acc_reg[PA_W-1:0])
            begin
                acc_reg <= {16'b0, pa_reg};
            end
        end
        else if (cmd.div_step)
        begin
            acc_reg <= {acc_reg[ACC_W-2:0], 1'b0};
        end

        if (cmd.cmp_pick)
        begin
            wide_reg <= (pa_reg > acc_reg[PA_W-1:0]);
        end

        if (cmd.div_start)
        begin
            div_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? rem_diff[REM_W-1:0] : rem_shift[REM_W-1:0];
            q_reg   <= {q_reg[SIZE_W-2:0], rem_ge};
            ovf_reg <= ovf_reg | q_reg[SIZE_W-1];
        end
    end

    // The padded low and high edges sum to low + high, so the margin drops out.
    assign sum_x  = 36'(low_x_reg) + 36'(high_x_reg) - $signed({1'b0, sx_reg});
    assign sum_y  = 36'(low_y_reg) + 36'(high_y_reg) - $signed({1'b0, sy_reg});
    assign half_x = sum_x[35:1];
    assign half_y = sum_y[35:1];

    function automatic logic [31:0] sat_corner(input logic signed [SIZE_W-1:0] v);
        logic signed [SIZE_W-1:0] r;
        begin
            if (v > CORNER_HI)
                r = CORNER_HI;
            else if (v < CORNER_LO)
                r = CORNER_LO;
            else
                r = v;
            sat_corner = r[31:0];
        end
    endfunction

    function automatic logic [30:0] sat_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        begin
            r = (v > SIZE_HI) ? SIZE_HI : v;
            sat_size = r[30:0];
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            view_x_reg      <= sat_corner(half_x);
            view_y_reg      <= sat_corner(half_y);
            view_width_reg  <= sat_size(sx_reg);
            view_height_reg <= sat_size(sy_reg);
        end
    end

    assign sts.wide         = wide_reg;
    assign sts.sy_zero      = (sy_reg == '0);
    assign sts.sy_below_min = (sy_reg < min_ext);

    assign view_x      = view_x_reg;
    assign view_y      = view_y_reg;
    assign view_width  = view_width_reg;
    assign view_height = view_height_reg;

endmodule

// File: rtl/point_set_view_framer.sv
// Point set view framer. Points arrive one per cycle as signed Q16.16 x and y
// pairs; the block keeps their running bounding box and, on the item flagged
// is_last, turns it into a view rectangle: the box is padded by border_margin
// on each side, widened in x or y to the viewport aspect around its centre,
// and scaled up if its height is below min_view_height (a zero height takes
// min_view_height and the matching aspect width). The result item gives the
// lower-left corner and the size, saturated to the Q16.16 range narrowed by
// COORD_BITS when that is below 32. Ordinary points are accepted at one per
// cycle. After the last point, in_ready stays low while one shared 35x16
// multiplier and a radix-2 divider run the aspect step, followed by a
// second multiply and divide when the zoom limit or the zero-height case
// needs them. Each divide makes one quotient bit per cycle over the
// 66-bit product. The result sits in an output register, so points of the
// next set are taken while it waits for out_ready. Configuration writes
// land at once through a plain write port and must only be made while the
// block is idle.
module point_set_view_framer #(
    parameter int COORD_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_we,
    input  logic [psvf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psvf_pkg::CFG_W-1:0]       cfg_wdata,

    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [31:0]               point_x,
    input  logic signed [31:0]               point_y,
    input  logic                             is_last,

    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [31:0]               view_x,
    output logic signed [31:0]               view_y,
    output logic [30:0]                      view_width,
    output logic [30:0]                      view_height
);

    psvf_pkg::cfg_t cfg;
    psvf_pkg::cmd_t cmd;
    psvf_pkg::sts_t sts;

    // Configuration register file.
    psvf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The controller owns the handshakes, the start-of-set flag and the
    // sequence of multiply and divide passes.
    psvf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .is_last   (is_last),
        .out_ready (out_ready),
        .sts       (sts),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // The datapath holds the bounding box, the sizes, the shared arithmetic
    // and the output register.
    psvf_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .cfg         (cfg),
        .point_x     (point_x),
        .point_y     (point_y),
        .sts         (sts),
        .view_x      (view_x),
        .view_y      (view_y),
        .view_width  (view_width),
        .view_height (view_height)
    );

endmodule

// File: rtl/psvf_checker.sv
module psvf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               is_last,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] view_x,
    input logic signed [31:0] view_y,
    input logic [30:0]        view_width,
    input logic [30:0]        view_height
);

    logic pending_reg;
    logic prev_valid_reg;
    logic prev_ready_reg;
    logic shown;
    logic last_taken;

    // A new result item is on the port when valid is high and the previous
    // cycle either had no item or had its item taken.
    assign shown      = out_valid && (!prev_valid_reg || prev_ready_reg);
    assign last_taken = in_valid && in_ready && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= 1'b0;
            prev_valid_reg <= 1'b0;
            prev_ready_reg <= 1'b0;
        end
        else
        begin
            pending_reg    <= last_taken || (pending_reg && !shown);
            prev_valid_reg <= out_valid;
            prev_ready_reg <= out_ready;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(view_x) && $stable(view_y)
            && $stable(view_width) && $stable(view_height))
        else $error("result item changed or dropped while stalled");

    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        last_taken |=> !in_ready)
        else $error("input still ready after the last point of a set");

    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        shown |-> pending_reg)
        else $error("result item without a closed point set");

    a_busy_until_result: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg && !shown |-> !in_ready)
        else $error("points accepted before the pending view was delivered");

endmodule

bind point_set_view_framer psvf_checker u_psvf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .is_last     (is_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .view_x      (view_x),
    .view_y      (view_y),
    .view_width  (view_width),
    .view_height (view_height)
);
